@@ sv/plob_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Price level order book package
// Shared constants, operation and status codes, and control structs.
// ----------------------------------------------------------------------------
package plob_pkg;

  localparam int DEF_MAX_LEVELS = 32;
  localparam int RESULT_LIMIT   = 32;
  localparam int OP_W           = 3;
  localparam int PRICE_W        = 31;
  localparam int QTY_W          = 32;
  localparam int TOP_W          = 6;
  localparam int ST_W           = 2;
  localparam int LIM_W          = 7;

  localparam logic [TOP_W-1:0] TOP_RESET = 6'd11;

  localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
  localparam logic [OP_W-1:0] OP_REDUCE = 3'd1;
  localparam logic [OP_W-1:0] OP_SET    = 3'd2;
  localparam logic [OP_W-1:0] OP_PRUNE  = 3'd3;
  localparam logic [OP_W-1:0] OP_QUERY  = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL = 2'd1;
  localparam logic [ST_W-1:0] ST_SAT  = 2'd2;

  typedef struct packed {
    logic load;
    logic look;
    logic apply;
    logic q_step;
    logic q_out;
  } plob_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            lim_zero;
    logic            q_in_lim;
    logic            q_end;
  } plob_stat_t;

endpackage

@@ sv/plob_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Price level order book controller
// Sequences lookup, update and query streaming, and owns the output valid.
// ----------------------------------------------------------------------------
module plob_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  plob_pkg::plob_stat_t stat,
  output plob_pkg::plob_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_LOOK  = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;
  localparam logic [1:0] S_QRY   = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       ovld_r, ovld_nxt;
  logic       out_free;

  assign out_free   = !ovld_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ovld_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.look  = 1'b1;
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        if (stat.op == plob_pkg::OP_QUERY && !stat.lim_zero) begin
          state_nxt = S_QRY;
        end else if (out_free) begin
          cmd.apply = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_QRY: begin
        if (!stat.q_in_lim || out_free) begin
          cmd.q_step = 1'b1;
          cmd.q_out  = stat.q_in_lim;
          if (stat.q_end) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.apply || cmd.q_out) begin
      ovld_nxt = 1'b1;
    end else if (out_tready) begin
      ovld_nxt = 1'b0;
    end else begin
      ovld_nxt = ovld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

endmodule

@@ sv/plob_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Price level order book datapath
// Sorted level cells for both sides, per-cell compare, shift and rotation.
// ----------------------------------------------------------------------------
module plob_dp #(
  parameter int MAX_LEVELS = plob_pkg::DEF_MAX_LEVELS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  plob_pkg::plob_cmd_t                  cmd,
  output plob_pkg::plob_stat_t                 stat,
  input  logic                                cfg_we,
  input  logic [plob_pkg::TOP_W-1:0]          cfg_wdata,
  input  logic [plob_pkg::OP_W-1:0]           in_op,
  input  logic                                in_side,
  input  logic [plob_pkg::PRICE_W-1:0]        in_price,
  input  logic [plob_pkg::QTY_W-1:0]          in_qty,
  output logic [plob_pkg::QTY_W-1:0]          o_rem,
  output logic                                o_clamped,
  output logic [plob_pkg::TOP_W-1:0]          o_pruned,
  output logic [plob_pkg::PRICE_W-1:0]        o_lprice,
  output logic [plob_pkg::QTY_W-1:0]          o_lqty,
  output logic                                o_lvalid,
  output logic [plob_pkg::ST_W-1:0]           o_status,
  output logic                                o_last
);

  localparam int CW = $clog2(MAX_LEVELS + 1);
  localparam int PW = plob_pkg::PRICE_W;
  localparam int QW = plob_pkg::QTY_W;
  localparam int LW = plob_pkg::LIM_W;

  logic [PW-1:0] prc_r [2][MAX_LEVELS];
  logic [PW-1:0] prc_nxt [2][MAX_LEVELS];
  logic [QW-1:0] qty_r [2][MAX_LEVELS];
  logic [QW-1:0] qty_nxt [2][MAX_LEVELS];
  logic [CW-1:0] cnt_r [2];
  logic [CW-1:0] cnt_nxt [2];
  logic [plob_pkg::TOP_W-1:0] top_r;

  logic [plob_pkg::OP_W-1:0] op_r;
  logic                      side_r;
  logic [PW-1:0]             price_r;
  logic [QW-1:0]             qin_r;

  logic [MAX_LEVELS-1:0] eq_c, ah_c, first_c, ins_c;
  logic [MAX_LEVELS-1:0] eq_m_r, ah_m_r, ge_m_r, ins_m_r;
  logic                  found_r;
  logic [QW-1:0]         mq_c, mq_r;
  logic [CW-1:0]         keep_c, keep_r, idx_or;
  logic [CW-1:0]         lim_c, lim_r, k_r;
  logic [CW-1:0]         n_sel;
  logic [LW-1:0]         lim_w;
  logic                  full;
  logic [QW:0]           sum;
  logic [QW-1:0]         upd_q, removed, red_q, rem;
  logic [plob_pkg::ST_W-1:0] st;

  assign n_sel = side_r ? cnt_r[1] : cnt_r[0];
  assign full  = (n_sel == CW'(MAX_LEVELS));

  always_comb begin
    mq_c   = '0;
    idx_or = '0;
    for (int i = 0; i < MAX_LEVELS; i++) begin
      eq_c[i] = (CW'(i) < n_sel) && (prc_r[side_r][i] == price_r);
      ah_c[i] = (CW'(i) < n_sel) &&
                (side_r ? (price_r > prc_r[side_r][i]) : (price_r < prc_r[side_r][i]));
    end
    for (int i = 0; i < MAX_LEVELS; i++) begin
      first_c[i] = ah_c[i] && ((i == 0) || !ah_c[(i > 0) ? i - 1 : 0]);
      ins_c[i]   = first_c[i] || (!(|ah_c) && (CW'(i) == n_sel));
      if (eq_c[i]) begin
        mq_c = mq_c | qty_r[side_r][i];
      end
      if (first_c[i]) begin
        idx_or = idx_or | CW'(i);
      end
    end
    keep_c = (|ah_c) ? idx_or : n_sel;
    lim_w  = ({1'b0, top_r} < LW'(n_sel)) ? {1'b0, top_r} : LW'(n_sel);
    if (lim_w > LW'(plob_pkg::RESULT_LIMIT)) begin
      lim_w = LW'(plob_pkg::RESULT_LIMIT);
    end
    lim_c = CW'(lim_w);
  end

  assign sum     = {1'b0, mq_r} + {1'b0, qin_r};
  assign upd_q   = (op_r == plob_pkg::OP_ADD) ? (sum[QW] ? '1 : sum[QW-1:0]) : qin_r;
  assign removed = (mq_r < qin_r) ? mq_r : qin_r;
  assign red_q   = mq_r - removed;
  assign rem     = found_r ? (qin_r - removed) : qin_r;

  always_comb begin
    if (found_r) begin
      st = (op_r == plob_pkg::OP_ADD && sum[QW]) ? plob_pkg::ST_SAT : plob_pkg::ST_OK;
    end else begin
      st = full ? plob_pkg::ST_FULL : plob_pkg::ST_OK;
    end
  end

  always_comb begin
    prc_nxt = prc_r;
    qty_nxt = qty_r;
    cnt_nxt = cnt_r;
    if (cmd.apply) begin
      unique case (op_r)
        plob_pkg::OP_ADD, plob_pkg::OP_SET: begin
          if (found_r) begin
            for (int i = 0; i < MAX_LEVELS; i++) begin
              if (eq_m_r[i]) begin
                qty_nxt[side_r][i] = upd_q;
              end
            end
          end else if (!full) begin
            for (int i = 0; i < MAX_LEVELS; i++) begin
              if (ins_m_r[i]) begin
                prc_nxt[side_r][i] = price_r;
                qty_nxt[side_r][i] = qin_r;
              end else if (i > 0 && ah_m_r[(i > 0) ? i - 1 : 0]) begin
                prc_nxt[side_r][i] = prc_r[side_r][(i > 0) ? i - 1 : 0];
                qty_nxt[side_r][i] = qty_r[side_r][(i > 0) ? i - 1 : 0];
              end
            end
            cnt_nxt[side_r] = n_sel + 1'b1;
          end
        end
        plob_pkg::OP_REDUCE: begin
          if (found_r) begin
            if (red_q != '0) begin
              for (int i = 0; i < MAX_LEVELS; i++) begin
                if (eq_m_r[i]) begin
                  qty_nxt[side_r][i] = red_q;
                end
              end
            end else begin
              for (int i = 0; i < MAX_LEVELS - 1; i++) begin
                if (ge_m_r[i]) begin
                  prc_nxt[side_r][i] = prc_r[side_r][i + 1];
                  qty_nxt[side_r][i] = qty_r[side_r][i + 1];
                end
              end
              cnt_nxt[side_r] = n_sel - 1'b1;
            end
          end
        end
        plob_pkg::OP_PRUNE: cnt_nxt[side_r] = keep_r;
        plob_pkg::OP_CLEAR: cnt_nxt[side_r] = '0;
        default: ;
      endcase
    end else if (cmd.q_step) begin
      for (int i = 0; i < MAX_LEVELS - 1; i++) begin
        if (CW'(i) < n_sel - 1'b1) begin
          prc_nxt[side_r][i] = prc_r[side_r][i + 1];
          qty_nxt[side_r][i] = qty_r[side_r][i + 1];
        end
      end
      for (int i = 0; i < MAX_LEVELS; i++) begin
        if (CW'(i) == n_sel - 1'b1) begin
          prc_nxt[side_r][i] = prc_r[side_r][0];
          qty_nxt[side_r][i] = qty_r[side_r][0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    prc_r <= prc_nxt;
    qty_r <= qty_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r[0] <= '0;
      cnt_r[1] <= '0;
      top_r    <= plob_pkg::TOP_RESET;
      k_r      <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (cfg_we) begin
        top_r <= cfg_wdata;
      end
      if (cmd.look) begin
        k_r <= '0;
      end else if (cmd.q_step) begin
        k_r <= k_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_op;
      side_r  <= in_side;
      price_r <= in_price;
      qin_r   <= in_qty;
    end
    if (cmd.look) begin
      eq_m_r  <= eq_c;
      ah_m_r  <= ah_c;
      ge_m_r  <= ah_c | eq_c;
      ins_m_r <= ins_c;
      found_r <= |eq_c;
      mq_r    <= mq_c;
      keep_r  <= keep_c;
      lim_r   <= lim_c;
    end
    if (cmd.apply) begin
      o_rem     <= '0;
      o_clamped <= 1'b0;
      o_pruned  <= '0;
      o_lprice  <= '0;
      o_lqty    <= '0;
      o_lvalid  <= 1'b0;
      o_status  <= plob_pkg::ST_OK;
      o_last    <= 1'b1;
      unique case (op_r)
        plob_pkg::OP_ADD, plob_pkg::OP_SET: o_status <= st;
        plob_pkg::OP_REDUCE: begin
          o_rem     <= rem;
          o_clamped <= (rem != '0);
        end
        plob_pkg::OP_PRUNE: o_pruned <= plob_pkg::TOP_W'(n_sel - keep_r);
        default: ;
      endcase
    end else if (cmd.q_out) begin
      o_rem     <= '0;
      o_clamped <= 1'b0;
      o_pruned  <= '0;
      o_lprice  <= prc_r[side_r][0];
      o_lqty    <= qty_r[side_r][0];
      o_lvalid  <= 1'b1;
      o_status  <= plob_pkg::ST_OK;
      o_last    <= (k_r == lim_r - 1'b1);
    end
  end

  assign stat.op       = op_r;
  assign stat.lim_zero = (lim_r == '0);
  assign stat.q_in_lim = (k_r < lim_r);
  assign stat.q_end    = (k_r == n_sel - 1'b1);

endmodule

@@ sv/price_level_order_book_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Price level order book core
// Two sorted price level tables with add, reduce, set, prune, query and clear.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake          Payload
// in_      input      tvalid / tready    tdata price, quantity; tuser op, side
// out_     output     tvalid / tready    tdata result fields; tlast last
// cfg_     input      we                 wdata top_count
//
// An update, prune or clear passes through the lookup and apply states, with
// its result registered when applied; the next item is taken back in idle.
// A query with a nonzero limit then enters a query state that rotates the side's
// level cells once, one cell a cycle unless a level waits on a stalled output,
// emitting levels within top_count and holding the input until the rotation ends.
// Reset empties both sides at once and sets top_count to eleven.
// A stalled output holds back the next result; one item can still be taken behind it.
module price_level_order_book_core #(
  parameter int MAX_LEVELS = plob_pkg::DEF_MAX_LEVELS
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // price[30:0], quantity[62:31]
  input  logic [3:0]   in_tuser,   // operation[2:0], side[3]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [111:0] out_tdata,  // remainder, clamped, pruned_count,
                                   // level_price, level_quantity, level_valid, status
  output logic         out_tlast,
  input  logic         cfg_we,
  input  logic [5:0]   cfg_wdata
);

  plob_pkg::plob_cmd_t  cmd;
  plob_pkg::plob_stat_t stat;

  logic [plob_pkg::QTY_W-1:0]   o_rem, o_lqty;
  logic                         o_clamped, o_lvalid;
  logic [plob_pkg::TOP_W-1:0]   o_pruned;
  logic [plob_pkg::PRICE_W-1:0] o_lprice;
  logic [plob_pkg::ST_W-1:0]    o_status;

  plob_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  plob_dp #(
    .MAX_LEVELS (MAX_LEVELS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_op     (in_tuser[2:0]),
    .in_side   (in_tuser[3]),
    .in_price  (in_tdata[30:0]),
    .in_qty    (in_tdata[62:31]),
    .o_rem     (o_rem),
    .o_clamped (o_clamped),
    .o_pruned  (o_pruned),
    .o_lprice  (o_lprice),
    .o_lqty    (o_lqty),
    .o_lvalid  (o_lvalid),
    .o_status  (o_status),
    .o_last    (out_tlast)
  );

  assign out_tdata = {7'd0, o_status, o_lvalid, o_lqty, o_lprice, o_pruned, o_clamped, o_rem};

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while an item is in progress");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[102]) |-> out_tlast)
    else $error("result without a level is not the final one");

  a_clamp_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[32] == (out_tdata[31:0] != 32'd0)))
    else $error("clamped flag disagrees with remainder");

endmodule

@@ verif/tb_price_level_order_book_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Price level order book core testbench
// Drives add, reduce, set, prune, query, clear and reserved operations with
// random gaps and output stalls, predicts every result from a behavioral copy
// of both level tables, and compares each output transaction field by field.
// ----------------------------------------------------------------------------
module tb_price_level_order_book_core;

  localparam logic [plob_pkg::OP_W-1:0] OP_RSV6 = 3'd6;
  localparam logic [plob_pkg::OP_W-1:0] OP_RSV7 = 3'd7;

  typedef struct {
    logic [plob_pkg::OP_W-1:0]    op;
    logic                         side;
    logic [plob_pkg::PRICE_W-1:0] price;
    logic [plob_pkg::QTY_W-1:0]   qty;
  } book_req_t;

  typedef struct packed {
    logic [plob_pkg::QTY_W-1:0]   remainder;
    logic                         clamped;
    logic [5:0]                   pruned;
    logic [plob_pkg::PRICE_W-1:0] lvl_price;
    logic [plob_pkg::QTY_W-1:0]   lvl_qty;
    logic                         lvl_valid;
    logic [plob_pkg::ST_W-1:0]    status;
    logic                         last;
  } book_rsp_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [63:0]  in_tdata = '0;
  logic [3:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [111:0] out_tdata;
  logic         out_tlast;
  logic         cfg_we = 1'b0;
  logic [5:0]   cfg_wdata = '0;

  book_req_t    req_q[$];
  book_rsp_t    rsp_q[$];
  book_req_t    cur_req;
  bit           req_taken = 1'b0;
  int           send_gap = 0;
  int           stall_cnt = 0;
  bit           gaps_on = 1'b1;
  int           errors = 0;
  int           quiet_cycles = 0;

  logic [plob_pkg::PRICE_W-1:0] book_px[2][plob_pkg::DEF_MAX_LEVELS];
  logic [plob_pkg::QTY_W-1:0]   book_qty[2][plob_pkg::DEF_MAX_LEVELS];
  int                           book_n[2];
  int                           model_top = 11;

  price_level_order_book_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit ahead(bit bid, logic [plob_pkg::PRICE_W-1:0] a,
                               logic [plob_pkg::PRICE_W-1:0] b);
    return bid ? (a > b) : (a < b);
  endfunction

  function automatic book_rsp_t blank_rsp();
    book_rsp_t r;
    r = '0;
    r.last = 1'b1;
    return r;
  endfunction

  task automatic apply_book_op(book_req_t r);
    int s, n, idx, pos, keep, lim;
    logic [32:0] sum;
    logic [plob_pkg::QTY_W-1:0] removed;
    book_rsp_t rsp;
    s = r.side;
    n = book_n[s];
    rsp = blank_rsp();
    idx = n;
    pos = n;
    for (int i = 0; i < n; i++) begin
      if (book_px[s][i] == r.price) begin
        idx = i;
        break;
      end
      if (ahead(r.side, r.price, book_px[s][i])) begin
        pos = i;
        break;
      end
    end
    case (r.op)
      plob_pkg::OP_ADD, plob_pkg::OP_SET: begin
        if (idx < n) begin
          if (r.op == plob_pkg::OP_ADD) begin
            sum = book_qty[s][idx] + r.qty;
            if (sum[32]) begin
              book_qty[s][idx] = '1;
              rsp.status = plob_pkg::ST_SAT;
            end else begin
              book_qty[s][idx] = sum[31:0];
            end
          end else begin
            book_qty[s][idx] = r.qty;
          end
        end else if (n >= plob_pkg::DEF_MAX_LEVELS) begin
          rsp.status = plob_pkg::ST_FULL;
        end else begin
          for (int i = n; i > pos; i--) begin
            book_px[s][i] = book_px[s][i-1];
            book_qty[s][i] = book_qty[s][i-1];
          end
          book_px[s][pos] = r.price;
          book_qty[s][pos] = r.qty;
          book_n[s] = n + 1;
        end
        rsp_q.push_back(rsp);
      end
      plob_pkg::OP_REDUCE: begin
        rsp.remainder = r.qty;
        if (idx < n) begin
          removed = (book_qty[s][idx] < r.qty) ? book_qty[s][idx] : r.qty;
          book_qty[s][idx] -= removed;
          rsp.remainder = r.qty - removed;
          if (book_qty[s][idx] == 0) begin
            for (int i = idx; i < n - 1; i++) begin
              book_px[s][i] = book_px[s][i+1];
              book_qty[s][i] = book_qty[s][i+1];
            end
            book_n[s] = n - 1;
          end
        end
        rsp.clamped = (rsp.remainder != 0);
        rsp_q.push_back(rsp);
      end
      plob_pkg::OP_PRUNE: begin
        keep = n;
        for (int i = 0; i < n; i++) begin
          if (ahead(r.side, r.price, book_px[s][i])) begin
            keep = i;
            break;
          end
        end
        book_n[s] = keep;
        rsp.pruned = 6'(n - keep);
        rsp_q.push_back(rsp);
      end
      plob_pkg::OP_QUERY: begin
        lim = model_top;
        if (lim > n) lim = n;
        if (lim > plob_pkg::RESULT_LIMIT) lim = plob_pkg::RESULT_LIMIT;
        if (lim == 0) begin
          rsp_q.push_back(rsp);
        end else begin
          for (int i = 0; i < lim; i++) begin
            rsp = blank_rsp();
            rsp.lvl_price = book_px[s][i];
            rsp.lvl_qty = book_qty[s][i];
            rsp.lvl_valid = 1'b1;
            rsp.last = (i + 1 == lim);
            rsp_q.push_back(rsp);
          end
        end
      end
      default: begin
        if (r.op == plob_pkg::OP_CLEAR) book_n[s] = 0;
        rsp_q.push_back(rsp);
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      apply_book_op(cur_req);
      req_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || req_taken)) begin
      req_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_tvalid <= 1'b0;
      end else if (req_q.size() > 0) begin
        cur_req = req_q.pop_front();
        in_tdata <= {1'b0, cur_req.qty, cur_req.price};
        in_tuser <= {cur_req.side, cur_req.op};
        in_tvalid <= 1'b1;
        send_gap = gaps_on ? $urandom_range(0, 14) : 0;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (stall_cnt > 0) begin
        stall_cnt--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    book_rsp_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[31:0], out_tdata[32], out_tdata[38:33], out_tdata[69:39],
             out_tdata[101:70], out_tdata[102], out_tdata[104:103], out_tlast};
      stall_cnt = gaps_on ? $urandom_range(0, 14) : 0;
      if (rsp_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected result %h", got);
      end else begin
        want = rsp_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) begin
            $display("ERROR: rem %h/%h clamp %b/%b pruned %0d/%0d",
                     want.remainder, got.remainder, want.clamped, got.clamped,
                     want.pruned, got.pruned);
            $display("       price %h/%h qty %h/%h valid %b/%b st %0d/%0d last %b/%b",
                     want.lvl_price, got.lvl_price, want.lvl_qty, got.lvl_qty,
                     want.lvl_valid, got.lvl_valid, want.status, got.status,
                     want.last, got.last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
      quiet_cycles = 0;
    end else if (++quiet_cycles >= 3000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic add_req(logic [plob_pkg::OP_W-1:0] op, logic side,
                         logic [plob_pkg::PRICE_W-1:0] price,
                         logic [plob_pkg::QTY_W-1:0] qty);
    book_req_t r;
    r.op = op;
    r.side = side;
    r.price = price;
    r.qty = qty;
    req_q.push_back(r);
  endtask

  task automatic drain();
    while (req_q.size() > 0 || in_tvalid || rsp_q.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_top(logic [5:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= val;
    model_top = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_items(int cnt);
    logic [plob_pkg::OP_W-1:0] op;
    logic [plob_pkg::PRICE_W-1:0] price;
    logic [plob_pkg::QTY_W-1:0] qty;
    int k;
    for (int i = 0; i < cnt; i++) begin
      k = $urandom_range(0, 99);
      if (k < 35) op = plob_pkg::OP_ADD;
      else if (k < 55) op = plob_pkg::OP_REDUCE;
      else if (k < 67) op = plob_pkg::OP_SET;
      else if (k < 75) op = plob_pkg::OP_PRUNE;
      else if (k < 90) op = plob_pkg::OP_QUERY;
      else if (k < 95) op = plob_pkg::OP_CLEAR;
      else op = ($urandom_range(0, 1) == 0) ? OP_RSV6 : OP_RSV7;
      price = ($urandom_range(0, 9) == 0) ? plob_pkg::PRICE_W'($urandom) :
              plob_pkg::PRICE_W'(1000 + $urandom_range(0, 40));
      qty = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 500);
      add_req(op, 1'($urandom_range(0, 1)), price, qty);
    end
  endtask

  initial begin
    book_n[0] = 0;
    book_n[1] = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed corner cases at the reset value of top_count.
    add_req(plob_pkg::OP_QUERY, 1'b1, 0, 0);
    add_req(plob_pkg::OP_ADD, 1'b0, 0, 32'hFFFF_FFFF);
    add_req(plob_pkg::OP_ADD, 1'b0, 0, 1);
    add_req(plob_pkg::OP_ADD, 1'b1, 31'h7FFF_FFFF, 0);
    add_req(plob_pkg::OP_ADD, 1'b1, 100, 50);
    add_req(plob_pkg::OP_ADD, 1'b1, 200, 70);
    add_req(plob_pkg::OP_REDUCE, 1'b1, 150, 9);
    add_req(plob_pkg::OP_REDUCE, 1'b1, 100, 80);
    add_req(plob_pkg::OP_REDUCE, 1'b1, 31'h7FFF_FFFF, 0);
    add_req(plob_pkg::OP_SET, 1'b0, 5, 33);
    add_req(plob_pkg::OP_SET, 1'b0, 5, 44);
    add_req(plob_pkg::OP_ADD, 1'b0, 9, 1);
    add_req(plob_pkg::OP_QUERY, 1'b0, 0, 0);
    add_req(plob_pkg::OP_PRUNE, 1'b0, 5, 0);
    add_req(plob_pkg::OP_QUERY, 1'b1, 0, 0);
    add_req(OP_RSV6, 1'b1, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
    add_req(OP_RSV7, 1'b0, 0, 0);
    add_req(plob_pkg::OP_CLEAR, 1'b1, 0, 0);
    add_req(plob_pkg::OP_QUERY, 1'b0, 31'h5555_5555, 32'hAAAA_AAAA);
    drain();

    // Fill the bid side beyond capacity and read back every level.
    write_top(6'd63);
    for (int i = 0; i < 34; i++) begin
      add_req(plob_pkg::OP_ADD, 1'b1, plob_pkg::PRICE_W'(2000 + 7 * i), plob_pkg::QTY_W'(i));
    end
    add_req(plob_pkg::OP_SET, 1'b1, 1, 5);
    add_req(plob_pkg::OP_QUERY, 1'b1, 0, 0);
    add_req(plob_pkg::OP_PRUNE, 1'b1, 2100, 0);
    add_req(plob_pkg::OP_QUERY, 1'b1, 0, 0);
    drain();

    write_top(6'd0);
    add_req(plob_pkg::OP_QUERY, 1'b1, 0, 0);
    add_req(plob_pkg::OP_CLEAR, 1'b1, 0, 0);
    random_items(10);
    drain();

    write_top(6'd1);
    random_items(10);
    drain();

    gaps_on = 1'b0;
    write_top(6'd32);
    random_items(10);
    drain();

    gaps_on = 1'b1;
    write_top(6'($urandom_range(2, 40)));
    random_items(10);
    drain();

    write_top(6'd11);
    random_items(10);
    drain();

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/plob_pkg.sv
sv/plob_ctrl.sv
sv/plob_dp.sv
sv/price_level_order_book_core.sv
verif/tb_price_level_order_book_core.sv
